FILE: design/assembly_token_scanner_unit_defines.svh
// assertion macros for the assembly token scanner
// used by the top level; needs signals named clk and rst_n in scope
`ifndef ASSEMBLY_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define ASSEMBLY_TOKEN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ATS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// next-cycle implication, disabled during reset
`define ATS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`endif

FILE: design/ats_pkg.sv
// shared types, codes and character classes for the assembly token scanner
// no dependencies
package ats_pkg;

    // scanner modes of the front part
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_MINUS   = 3'd4
    } scan_mode_t;

    // token kinds as seen on the output
    typedef enum logic [2:0] {
        KIND_MNEMONIC  = 3'd0,
        KIND_REGISTER  = 3'd1,
        KIND_IMMEDIATE = 3'd2,
        KIND_COMMA     = 3'd3,
        KIND_COLON     = 3'd4,
        KIND_ERROR     = 3'd5,
        KIND_END       = 3'd6
    } kind_t;

    // emitter states of the back part
    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_LOAD = 3'd1,
        B_TEXT = 3'd2,
        B_ONE  = 3'd3,
        B_END  = 3'd4
    } back_state_t;

    // what one accepted item asks the back part to send
    typedef struct packed {
        logic  flush_en;
        kind_t flush_kind;
        logic  one_en;
        kind_t one_kind;
        logic  end_en;
    } job_ctl_t;

    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

FILE: design/ats_front.sv
// front part: accepts characters, tracks position, classifies and collects tokens
// depends on ats_pkg; writes token text into the back part's store
module ats_front #(
    parameter int TEXT_CAPACITY = 64,
    parameter int LINE_BITS     = 16,
    parameter int COLUMN_BITS   = 12,
    parameter int CNT_W         = 6,
    parameter int ADDR_W        = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_char,
    input  logic                   in_eoi,
    input  logic                   q_empty,
    input  logic                   back_busy,
    output logic                   push,
    output ats_pkg::job_ctl_t      ctl,
    output logic                   job_bank,
    output logic [CNT_W-1:0]       job_count,
    output logic [LINE_BITS-1:0]   job_sline,
    output logic [COLUMN_BITS-1:0] job_scol,
    output logic [LINE_BITS-1:0]   job_cline,
    output logic [COLUMN_BITS-1:0] job_ccol,
    output logic [7:0]             job_char,
    output logic                   wr_en,
    output logic [ADDR_W:0]        wr_addr,
    output logic [7:0]             wr_data
);

    localparam logic [CNT_W-1:0] STORE_MAX = CNT_W'(TEXT_CAPACITY - 1);

    ats_pkg::scan_mode_t      mode_reg, mode_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [COLUMN_BITS-1:0]   col_reg, col_next;
    logic [LINE_BITS-1:0]     sline_reg, sline_next;
    logic [COLUMN_BITS-1:0]   scol_reg, scol_next;
    logic                     first_r_reg, first_r_next;
    logic                     reg_flag_reg, reg_flag_next;
    logic                     bank_reg, bank_next;

    logic                     accept;
    logic [LINE_BITS-1:0]     nl;
    logic [COLUMN_BITS-1:0]   nc;
    ats_pkg::kind_t           flush_kind;

    // classification of a character seen between tokens
    ats_pkg::scan_mode_t      ic_mode;
    logic                     ic_begin;
    ats_pkg::scan_mode_t      ic_begin_mode;
    logic                     ic_one;
    ats_pkg::kind_t           ic_one_kind;

    // per-item actions
    logic                     do_flush, do_store, do_begin, use_idle;
    ats_pkg::scan_mode_t      begin_mode;

    // one item in flight: wait for the back part to drain
    assign in_ready = q_empty && !back_busy;
    assign accept   = in_valid && in_ready;

    // position after counting this character, saturating
    always_comb
    begin
        nl = line_reg;
        nc = col_reg;
        if (in_char == ats_pkg::CH_NEWLINE)
        begin
            if (!(&line_reg))
                nl = line_reg + 1'b1;
            nc = '0;
        end
        else if (!(&col_reg))
        begin
            nc = col_reg + 1'b1;
        end
    end

    // idle classification
    always_comb
    begin
        ic_mode       = ats_pkg::MODE_IDLE;
        ic_begin      = 1'b0;
        ic_begin_mode = ats_pkg::MODE_WORD;
        ic_one        = 1'b0;
        ic_one_kind   = ats_pkg::KIND_ERROR;
        if (ats_pkg::is_space(in_char))
        begin
            ic_mode = ats_pkg::MODE_IDLE;
        end
        else if (in_char == ats_pkg::CH_SEMI)
        begin
            ic_mode = ats_pkg::MODE_COMMENT;
        end
        else if (ats_pkg::is_letter(in_char))
        begin
            ic_begin      = 1'b1;
            ic_begin_mode = ats_pkg::MODE_WORD;
        end
        else if (ats_pkg::is_digit(in_char))
        begin
            ic_begin      = 1'b1;
            ic_begin_mode = ats_pkg::MODE_NUMBER;
        end
        else if (in_char == ats_pkg::CH_MINUS)
        begin
            ic_begin      = 1'b1;
            ic_begin_mode = ats_pkg::MODE_MINUS;
        end
        else if (in_char == ats_pkg::CH_COMMA)
        begin
            ic_one      = 1'b1;
            ic_one_kind = ats_pkg::KIND_COMMA;
        end
        else if (in_char == ats_pkg::CH_COLON)
        begin
            ic_one      = 1'b1;
            ic_one_kind = ats_pkg::KIND_COLON;
        end
        else
        begin
            ic_one      = 1'b1;
            ic_one_kind = ats_pkg::KIND_ERROR;
        end
    end

    // kind of the pending token
    always_comb
    begin
        unique case (mode_reg)
            ats_pkg::MODE_WORD:
                flush_kind = reg_flag_reg ? ats_pkg::KIND_REGISTER : ats_pkg::KIND_MNEMONIC;
            ats_pkg::MODE_NUMBER:
                flush_kind = ats_pkg::KIND_IMMEDIATE;
            default:
                flush_kind = ats_pkg::KIND_ERROR;
        endcase
    end

    // next state and job for the accepted item
    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        sline_next    = sline_reg;
        scol_next     = scol_reg;
        first_r_next  = first_r_reg;
        reg_flag_next = reg_flag_reg;
        bank_next     = bank_reg;
        do_flush      = 1'b0;
        do_store      = 1'b0;
        do_begin      = 1'b0;
        use_idle      = 1'b0;
        begin_mode    = ic_begin_mode;
        ctl           = '0;
        wr_en         = 1'b0;
        wr_addr       = {bank_reg, count_reg[ADDR_W-1:0]};
        wr_data       = in_char;

        if (accept)
        begin
            if (in_eoi)
            begin
                do_flush   = mode_reg inside {ats_pkg::MODE_WORD, ats_pkg::MODE_NUMBER,
                                              ats_pkg::MODE_MINUS};
                ctl.end_en = 1'b1;
                mode_next  = ats_pkg::MODE_IDLE;
                count_next = '0;
                line_next  = LINE_BITS'(1);
                col_next   = '0;
                sline_next = LINE_BITS'(1);
                scol_next  = '0;
            end
            else
            begin
                line_next = nl;
                col_next  = nc;
                unique case (mode_reg)
                    ats_pkg::MODE_COMMENT:
                    begin
                        if (in_char == ats_pkg::CH_NEWLINE)
                            mode_next = ats_pkg::MODE_IDLE;
                    end
                    ats_pkg::MODE_WORD:
                    begin
                        if (ats_pkg::is_letter(in_char) || ats_pkg::is_digit(in_char))
                            do_store = 1'b1;
                        else
                        begin
                            do_flush = 1'b1;
                            use_idle = 1'b1;
                        end
                    end
                    ats_pkg::MODE_NUMBER:
                    begin
                        if (ats_pkg::is_digit(in_char))
                            do_store = 1'b1;
                        else
                        begin
                            do_flush = 1'b1;
                            use_idle = 1'b1;
                        end
                    end
                    ats_pkg::MODE_MINUS:
                    begin
                        if (ats_pkg::is_digit(in_char))
                        begin
                            mode_next = ats_pkg::MODE_NUMBER;
                            do_store  = 1'b1;
                        end
                        else
                        begin
                            do_flush = 1'b1;
                            use_idle = 1'b1;
                        end
                    end
                    default:
                        use_idle = 1'b1;
                endcase

                if (use_idle)
                begin
                    mode_next   = ic_mode;
                    count_next  = '0;
                    do_begin    = ic_begin;
                    ctl.one_en  = ic_one;
                    ctl.one_kind = ic_one_kind;
                end

                // append to the current token while there is room
                if (do_store && (count_reg < STORE_MAX))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if ((count_reg == CNT_W'(1)) && first_r_reg && ats_pkg::is_digit(in_char))
                        reg_flag_next = 1'b1;
                end

                // new token goes to the other bank so a flush can still read
                if (do_begin)
                begin
                    mode_next     = begin_mode;
                    bank_next     = !bank_reg;
                    count_next    = CNT_W'(1);
                    sline_next    = nl;
                    scol_next     = nc;
                    first_r_next  = (in_char == ats_pkg::CH_R);
                    reg_flag_next = 1'b0;
                    wr_en         = 1'b1;
                    wr_addr       = {!bank_reg, {ADDR_W{1'b0}}};
                end
            end
            ctl.flush_en   = do_flush;
            ctl.flush_kind = flush_kind;
        end
    end

    assign push      = ctl.flush_en || ctl.one_en || ctl.end_en;
    assign job_bank  = bank_reg;
    assign job_count = count_reg;
    assign job_sline = sline_reg;
    assign job_scol  = scol_reg;
    assign job_cline = in_eoi ? line_reg : nl;
    assign job_ccol  = in_eoi ? col_reg : nc;
    assign job_char  = in_char;

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ats_pkg::MODE_IDLE;
            count_reg    <= '0;
            line_reg     <= LINE_BITS'(1);
            col_reg      <= '0;
            sline_reg    <= LINE_BITS'(1);
            scol_reg     <= '0;
            first_r_reg  <= 1'b0;
            reg_flag_reg <= 1'b0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            sline_reg    <= sline_next;
            scol_reg     <= scol_next;
            first_r_reg  <= first_r_next;
            reg_flag_reg <= reg_flag_next;
            bank_reg     <= bank_next;
        end
    end

endmodule

FILE: design/ats_queue.sv
// two-entry job queue between the front and back parts
// no package dependencies
module ats_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign empty    = (fill_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

FILE: design/ats_back.sv
// back part: token text store; one result per cycle unless stalled
// depends on ats_pkg; fed by the job queue and the front part's writes
module ats_back #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    parameter int CNT_W       = 6,
    parameter int ADDR_W      = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [ADDR_W:0]        wr_addr,
    input  logic [7:0]             wr_data,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  ats_pkg::job_ctl_t      ctl,
    input  logic                   job_bank,
    input  logic [CNT_W-1:0]       job_count,
    input  logic [LINE_BITS-1:0]   job_sline,
    input  logic [COLUMN_BITS-1:0] job_scol,
    input  logic [LINE_BITS-1:0]   job_cline,
    input  logic [COLUMN_BITS-1:0] job_ccol,
    input  logic [7:0]             job_char,
    output logic                   busy,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ats_pkg::kind_t         out_kind,
    output logic [7:0]             out_char,
    output logic [LINE_BITS-1:0]   out_line,
    output logic [COLUMN_BITS-1:0] out_col,
    output logic                   out_done,
    output logic                   out_last
);

    localparam int MEM_DEPTH = 2 ** (ADDR_W + 1);

    // two banks of token text
    logic [7:0] text_mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;
    logic       rd_en;
    logic [ADDR_W:0] rd_addr;

    ats_pkg::back_state_t     state_reg, state_next;
    ats_pkg::job_ctl_t        ctl_reg, ctl_next;
    logic                     bank_reg, bank_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [LINE_BITS-1:0]     sline_reg, sline_next;
    logic [COLUMN_BITS-1:0]   scol_reg, scol_next;
    logic [LINE_BITS-1:0]     cline_reg, cline_next;
    logic [COLUMN_BITS-1:0]   ccol_reg, ccol_next;
    logic [7:0]               ch_reg, ch_next;

    logic                     ovalid_reg, ovalid_next;
    ats_pkg::kind_t           okind_reg, okind_next;
    logic [7:0]               ochar_reg, ochar_next;
    logic [LINE_BITS-1:0]     oline_reg, oline_next;
    logic [COLUMN_BITS-1:0]   ocol_reg, ocol_next;
    logic                     odone_reg, odone_next;
    logic                     olast_reg, olast_next;

    logic                     slot_free;
    logic [CNT_W-1:0]         idx_inc;
    logic                     text_end;

    assign slot_free = !ovalid_reg || out_ready;
    assign idx_inc   = CNT_W'(idx_reg + 1'b1);
    assign text_end  = (idx_inc == cnt_reg);
    assign busy      = (state_reg != ats_pkg::B_IDLE);

    // text store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            text_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= text_mem[rd_addr];
    end

    // emitter sequencing
    always_comb
    begin
        state_next  = state_reg;
        ctl_next    = ctl_reg;
        bank_next   = bank_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        cline_next  = cline_reg;
        ccol_next   = ccol_reg;
        ch_next     = ch_reg;
        ovalid_next = out_ready ? 1'b0 : ovalid_reg;
        okind_next  = okind_reg;
        ochar_next  = ochar_reg;
        oline_next  = oline_reg;
        ocol_next   = ocol_reg;
        odone_next  = odone_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {bank_reg, idx_inc[ADDR_W-1:0]};

        unique case (state_reg)
            ats_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ctl_next   = ctl;
                    bank_next  = job_bank;
                    cnt_next   = job_count;
                    idx_next   = '0;
                    sline_next = job_sline;
                    scol_next  = job_scol;
                    cline_next = job_cline;
                    ccol_next  = job_ccol;
                    ch_next    = job_char;
                    if (ctl.flush_en)
                        state_next = ats_pkg::B_LOAD;
                    else if (ctl.one_en)
                        state_next = ats_pkg::B_ONE;
                    else
                        state_next = ats_pkg::B_END;
                end
            end
            ats_pkg::B_LOAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = {bank_reg, {ADDR_W{1'b0}}};
                state_next = ats_pkg::B_TEXT;
            end
            ats_pkg::B_TEXT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = ctl_reg.flush_kind;
                    ochar_next  = rd_data_reg;
                    oline_next  = sline_reg;
                    ocol_next   = scol_reg;
                    odone_next  = text_end;
                    olast_next  = text_end && !ctl_reg.one_en && !ctl_reg.end_en;
                    idx_next    = idx_inc;
                    if (text_end)
                    begin
                        if (ctl_reg.one_en)
                            state_next = ats_pkg::B_ONE;
                        else if (ctl_reg.end_en)
                            state_next = ats_pkg::B_END;
                        else
                            state_next = ats_pkg::B_IDLE;
                    end
                    else
                    begin
                        // prefetch the next character
                        rd_en = 1'b1;
                    end
                end
            end
            ats_pkg::B_ONE:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = ctl_reg.one_kind;
                    ochar_next  = ch_reg;
                    oline_next  = cline_reg;
                    ocol_next   = ccol_reg;
                    odone_next  = 1'b1;
                    olast_next  = 1'b1;
                    state_next  = ats_pkg::B_IDLE;
                end
            end
            ats_pkg::B_END:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = ats_pkg::KIND_END;
                    ochar_next  = 8'h00;
                    oline_next  = cline_reg;
                    ocol_next   = ccol_reg;
                    odone_next  = 1'b1;
                    olast_next  = 1'b1;
                    state_next  = ats_pkg::B_IDLE;
                end
            end
            default:
                state_next = ats_pkg::B_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ats_pkg::B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        ctl_reg   <= ctl_next;
        bank_reg  <= bank_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        sline_reg <= sline_next;
        scol_reg  <= scol_next;
        cline_reg <= cline_next;
        ccol_reg  <= ccol_next;
        ch_reg    <= ch_next;
        okind_reg <= okind_next;
        ochar_reg <= ochar_next;
        oline_reg <= oline_next;
        ocol_reg  <= ocol_next;
        odone_reg <= odone_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_char  = ochar_reg;
    assign out_line  = oline_reg;
    assign out_col   = ocol_reg;
    assign out_done  = odone_reg;
    assign out_last  = olast_reg;

endmodule

FILE: design/assembly_token_scanner_unit.sv
// top level of the assembly token scanner: front, job queue, back
// depends on ats_pkg, ats_front, ats_queue, ats_back and the defines header
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata = char_in, tlast = end_of_input
//  m_axis    out  m_axis_tvalid/tready       tdata = text_char, token_line, token_column
//                                            tuser = kind, token_done; tlast = run_last
//
// an item with no results does not hold the input; an item with results holds the input
// until the back emitter has sent them, since only one such item is in flight
// meanwhile the queue is popped, any token text passes the text store's registered read,
// and each result is sent before the next accept
// reset brings line to 1 and column to 0; the text store needs no clearing pass
// a low m_axis_tready holds the output register, which stalls the emitter and the input
`include "assembly_token_scanner_unit_defines.svh"

module assembly_token_scanner_unit #(
    parameter int TEXT_CAPACITY = 64,
    parameter int LINE_BITS     = 16,
    parameter int COLUMN_BITS   = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] char_in
    input  logic              s_axis_tlast,   // end_of_input
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // text_char, token_line, token_column, zero pad
    output logic [((8 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [3:0]        m_axis_tuser,   // [2:0] kind, [3] token_done
    output logic              m_axis_tlast    // run_last
);

    localparam int DATA_W = ((8 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(TEXT_CAPACITY);
    localparam int ADDR_W = (TEXT_CAPACITY > 2) ? $clog2(TEXT_CAPACITY - 1) : 1;
    localparam int JOB_W  = $bits(ats_pkg::job_ctl_t) + 1 + CNT_W
                            + 2 * LINE_BITS + 2 * COLUMN_BITS + 8;

    ats_pkg::job_ctl_t        f_ctl, b_ctl;
    logic                     f_push, q_pop, q_empty, back_busy;
    logic                     f_bank, b_bank;
    logic [CNT_W-1:0]         f_count, b_count;
    logic [LINE_BITS-1:0]     f_sline, b_sline, f_cline, b_cline;
    logic [COLUMN_BITS-1:0]   f_scol, b_scol, f_ccol, b_ccol;
    logic [7:0]               f_char, b_char;
    logic                     wr_en;
    logic [ADDR_W:0]          wr_addr;
    logic [7:0]               wr_data;
    logic [JOB_W-1:0]         q_in, q_out;

    ats_pkg::kind_t           out_kind;
    logic [7:0]               out_char;
    logic [LINE_BITS-1:0]     out_line;
    logic [COLUMN_BITS-1:0]   out_col;
    logic                     out_done;
    logic                     end_out;

    // classifier and position tracking
    ats_front #(
        .TEXT_CAPACITY (TEXT_CAPACITY),
        .LINE_BITS     (LINE_BITS),
        .COLUMN_BITS   (COLUMN_BITS),
        .CNT_W         (CNT_W),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .in_eoi    (s_axis_tlast),
        .q_empty   (q_empty),
        .back_busy (back_busy),
        .push      (f_push),
        .ctl       (f_ctl),
        .job_bank  (f_bank),
        .job_count (f_count),
        .job_sline (f_sline),
        .job_scol  (f_scol),
        .job_cline (f_cline),
        .job_ccol  (f_ccol),
        .job_char  (f_char),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // job queue
    assign q_in = {f_ctl, f_bank, f_count, f_sline, f_scol, f_cline, f_ccol, f_char};
    assign {b_ctl, b_bank, b_count, b_sline, b_scol, b_cline, b_ccol, b_char} = q_out;

    ats_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (q_in),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    // text store and result emitter
    ats_back #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .ctl       (b_ctl),
        .job_bank  (b_bank),
        .job_count (b_count),
        .job_sline (b_sline),
        .job_scol  (b_scol),
        .job_cline (b_cline),
        .job_ccol  (b_ccol),
        .job_char  (b_char),
        .busy      (back_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_char  (out_char),
        .out_line  (out_line),
        .out_col   (out_col),
        .out_done  (out_done),
        .out_last  (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = DATA_W'({out_col, out_line, out_char});
    assign m_axis_tuser = {out_done, out_kind};
    assign end_out      = m_axis_tvalid && (out_kind == ats_pkg::KIND_END);

    // end of input always leaves a job behind for the end token
    `ATS_ASSERT_NEXT(a_eoi_queued, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_empty)
    // the end token closes both the token and the item
    `ATS_ASSERT_IMPL(a_end_closes, end_out, m_axis_tlast && out_done)
    // the last result of an item always ends a token
    `ATS_ASSERT_IMPL(a_last_is_done, m_axis_tvalid && m_axis_tlast, m_axis_tuser[3])

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for assembly_token_scanner_unit: source text in, token beats out
// holds its own scanner model that predicts every output beat; needs ats_pkg and the RTL
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_KEEP   = 63;
    localparam int STALL_LIMIT = 4000;
    localparam int DATA_W      = 40;

    // one output beat as the block should send it
    typedef struct {
        ats_pkg::kind_t kind;
        logic [7:0]     ch;
        logic [15:0]    line;
        logic [11:0]    col;
        logic           done;
        logic           last;
    } token_beat_t;

    // one source item waiting to be sent
    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
    } src_item_t;

    typedef enum logic [1:0] {
        CC_SPACE,
        CC_LETTER,
        CC_DIGIT,
        CC_OTHER
    } char_class_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [3:0]        m_axis_tuser;
    logic              m_axis_tlast;

    src_item_t   source_q[$];
    token_beat_t token_beats_q[$];
    token_beat_t item_beats_q[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic item_taken = 1'b0;

    // scanner state as predicted
    ats_pkg::scan_mode_t sc_mode = ats_pkg::MODE_IDLE;
    logic [7:0]  sc_text [TEXT_KEEP];
    int          sc_count = 0;
    logic [15:0] cur_line = 16'd1;
    logic [11:0] cur_col = 12'd0;
    logic [15:0] tok_line = 16'd1;
    logic [11:0] tok_col = 12'd0;

    assembly_token_scanner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- model

    function automatic char_class_t classify(logic [7:0] c);
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            return CC_SPACE;
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            return CC_LETTER;
        if (c >= "0" && c <= "9")
            return CC_DIGIT;
        return CC_OTHER;
    endfunction

    function automatic void add_beat(ats_pkg::kind_t k, logic [7:0] c, logic [15:0] ln,
                                     logic [11:0] cl, logic dn);
        token_beat_t b;
        b.kind = k;
        b.ch   = c;
        b.line = ln;
        b.col  = cl;
        b.done = dn;
        b.last = 1'b0;
        item_beats_q.push_back(b);
    endfunction

    function automatic void keep_char(logic [7:0] c);
        if (sc_count < TEXT_KEEP)
        begin
            sc_text[sc_count] = c;
            sc_count++;
        end
    endfunction

    function automatic void open_token(ats_pkg::scan_mode_t m, logic [7:0] c);
        sc_mode  = m;
        sc_count = 0;
        tok_line = cur_line;
        tok_col  = cur_col;
        keep_char(c);
    endfunction

    // send out the pending token text, if any
    function automatic void flush_text();
        ats_pkg::kind_t k;
        case (sc_mode)
            ats_pkg::MODE_WORD:
                k = (sc_count >= 2 && sc_text[0] == ats_pkg::CH_R
                     && classify(sc_text[1]) == CC_DIGIT)
                    ? ats_pkg::KIND_REGISTER : ats_pkg::KIND_MNEMONIC;
            ats_pkg::MODE_NUMBER: k = ats_pkg::KIND_IMMEDIATE;
            ats_pkg::MODE_MINUS:  k = ats_pkg::KIND_ERROR;
            default:              return;
        endcase
        for (int i = 0; i < sc_count; i++)
            add_beat(k, sc_text[i], tok_line, tok_col, i + 1 == sc_count);
        sc_count = 0;
        sc_mode  = ats_pkg::MODE_IDLE;
    endfunction

    // a character seen between tokens
    function automatic void start_char(logic [7:0] c);
        char_class_t cc;
        cc = classify(c);
        sc_mode = ats_pkg::MODE_IDLE;
        if (cc == CC_SPACE)
            return;
        if (c == ats_pkg::CH_SEMI)
            sc_mode = ats_pkg::MODE_COMMENT;
        else if (cc == CC_LETTER)
            open_token(ats_pkg::MODE_WORD, c);
        else if (cc == CC_DIGIT)
            open_token(ats_pkg::MODE_NUMBER, c);
        else if (c == ats_pkg::CH_MINUS)
            open_token(ats_pkg::MODE_MINUS, c);
        else if (c == ats_pkg::CH_COMMA)
            add_beat(ats_pkg::KIND_COMMA, c, cur_line, cur_col, 1'b1);
        else if (c == ats_pkg::CH_COLON)
            add_beat(ats_pkg::KIND_COLON, c, cur_line, cur_col, 1'b1);
        else
            add_beat(ats_pkg::KIND_ERROR, c, cur_line, cur_col, 1'b1);
    endfunction

    // predict all beats caused by one source item
    function automatic void predict_item(src_item_t it);
        char_class_t cc;
        token_beat_t b;
        item_beats_q.delete();
        cc = classify(it.ch);
        if (it.eoi)
        begin
            flush_text();
            add_beat(ats_pkg::KIND_END, 8'h00, cur_line, cur_col, 1'b1);
            sc_mode  = ats_pkg::MODE_IDLE;
            sc_count = 0;
            cur_line = 16'd1;
            cur_col  = 12'd0;
            tok_line = 16'd1;
            tok_col  = 12'd0;
        end
        else
        begin
            if (it.ch == ats_pkg::CH_NEWLINE)
            begin
                if (cur_line != 16'hFFFF)
                    cur_line++;
                cur_col = 12'd0;
            end
            else if (cur_col != 12'hFFF)
                cur_col++;

            case (sc_mode)
                ats_pkg::MODE_COMMENT:
                    if (it.ch == ats_pkg::CH_NEWLINE)
                        sc_mode = ats_pkg::MODE_IDLE;
                ats_pkg::MODE_WORD:
                    if (cc == CC_LETTER || cc == CC_DIGIT)
                        keep_char(it.ch);
                    else
                    begin
                        flush_text();
                        start_char(it.ch);
                    end
                ats_pkg::MODE_NUMBER:
                    if (cc == CC_DIGIT)
                        keep_char(it.ch);
                    else
                    begin
                        flush_text();
                        start_char(it.ch);
                    end
                ats_pkg::MODE_MINUS:
                    if (cc == CC_DIGIT)
                    begin
                        sc_mode = ats_pkg::MODE_NUMBER;
                        keep_char(it.ch);
                    end
                    else
                    begin
                        flush_text();
                        start_char(it.ch);
                    end
                default:
                    start_char(it.ch);
            endcase
        end
        if (item_beats_q.size() > 0)
        begin
            b = item_beats_q.pop_back();
            b.last = 1'b1;
            item_beats_q.push_back(b);
        end
        foreach (item_beats_q[i])
            token_beats_q.push_back(item_beats_q[i]);
    endfunction

    // ---------------------------------------------------------------- driver

    // source side: next item goes out at the falling edge, predicted as it appears
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!s_axis_tvalid || item_taken)
            begin
                if (source_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin : present_item
                    src_item_t it;
                    it = source_q.pop_front();
                    predict_item(it);
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= it.ch;
                    s_axis_tlast  <= it.eoi;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // result side back-pressure
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- monitor

    // sample both handshakes at the rising edge and check each result
    always @(posedge clk)
    begin : result_check
        token_beat_t want;
        item_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (token_beats_q.size() == 0)
            begin
                $error("result with no expected beat: tdata %0h tuser %0h",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = token_beats_q.pop_front();
                if (m_axis_tuser[2:0] !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, got %0d", want.kind,
                           m_axis_tuser[2:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:0] !== want.ch)
                begin
                    $error("text_char mismatch: expected %0h, got %0h", want.ch,
                           m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[23:8] !== want.line)
                begin
                    $error("token_line mismatch: expected %0d, got %0d", want.line,
                           m_axis_tdata[23:8]);
                    mismatch_count++;
                end
                if (m_axis_tdata[35:24] !== want.col)
                begin
                    $error("token_column mismatch: expected %0d, got %0d", want.col,
                           m_axis_tdata[35:24]);
                    mismatch_count++;
                end
                if (m_axis_tuser[3] !== want.done)
                begin
                    $error("token_done mismatch: expected %0d, got %0d", want.done,
                           m_axis_tuser[3]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("run_last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[assembly_token_scanner_unit] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_char(logic [7:0] c);
        src_item_t it;
        it.eoi = 1'b0;
        it.ch  = c;
        source_q.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // end of input, with a random byte on the ignored char field
    task automatic push_eoi();
        src_item_t it;
        it.eoi = 1'b1;
        it.ch  = 8'($urandom_range(255));
        source_q.push_back(it);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(1) ? rand_letter() : rand_digit();
    endfunction

    // mostly well-formed token runs, some noise and broken pieces
    task automatic add_random_tokens(int target);
        int   made;
        int   pick;
        int   len;
        int   start_size;
        logic [7:0] ws [6];
        ws = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        made = 0;
        while (made < target)
        begin
            start_size = source_q.size();
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                // word, some of them register-like
                if ($urandom_range(3) == 0)
                begin
                    push_char(ats_pkg::CH_R);
                    if ($urandom_range(2) != 0)
                        push_char(rand_digit());
                end
                else
                    push_char(rand_letter());
                repeat ($urandom_range(5)) push_char(rand_alnum());
            end
            else if (pick < 40)
            begin
                if ($urandom_range(9) < 3)
                    push_char(ats_pkg::CH_MINUS);
                repeat ($urandom_range(5, 1)) push_char(rand_digit());
            end
            else if (pick < 50)
                push_char($urandom_range(1) ? ats_pkg::CH_COMMA : ats_pkg::CH_COLON);
            else if (pick < 65)
                push_char(ws[$urandom_range(5)]);
            else if (pick < 73)
                push_char(ats_pkg::CH_NEWLINE);
            else if (pick < 78)
            begin
                // comment to the end of the line
                push_char(ats_pkg::CH_SEMI);
                repeat ($urandom_range(6)) push_char(8'($urandom_range(8'h7E, 8'h20)));
                push_char(ats_pkg::CH_NEWLINE);
            end
            else if (pick < 82)
            begin
                // lone minus followed by anything
                push_char(ats_pkg::CH_MINUS);
                push_char(8'($urandom_range(255)));
            end
            else if (pick < 92)
                push_char(8'($urandom_range(255)));
            else if (pick < 95)
            begin
                // short token ended directly by a comma
                len = $urandom_range(3, 1);
                if ($urandom_range(1))
                begin
                    push_char(rand_letter());
                    repeat (len - 1) push_char(rand_alnum());
                end
                else
                begin
                    push_char(ats_pkg::CH_MINUS);
                    repeat (len) push_char(rand_digit());
                end
                push_char(ats_pkg::CH_COMMA);
            end
            else
                push_eoi();
            made += source_q.size() - start_size;
        end
    endtask

    task automatic wait_drained();
        while (source_q.size() > 0 || s_axis_tvalid || token_beats_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (phase == 0)
            begin
                // register test, lone minus, minus before a number, comment
                push_text("R5 R,Rx:--3-x;c\n");
                // NUL and high bytes are errors, carriage return is whitespace
                push_char(8'h00);
                push_char(8'hFF);
                push_char(8'h0D);
                // lone minus pending at end of input
                push_char(ats_pkg::CH_MINUS);
                push_eoi();
                // open comment dropped at end of input
                push_text(";a");
                push_eoi();
                // end token at column zero
                push_char(ats_pkg::CH_NEWLINE);
                push_eoi();
                // word past the text store, ended by a comma
                push_char(rand_letter());
                repeat (65) push_char(rand_alnum());
                push_char(ats_pkg::CH_COMMA);
            end
            add_random_tokens(14);
            wait_drained();
        end
        push_eoi();
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && token_beats_q.size() == 0)
            $display("[assembly_token_scanner_unit] OK");
        else
            $display("[assembly_token_scanner_unit] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/ats_pkg.sv
design/ats_front.sv
design/ats_queue.sv
design/ats_back.sv
design/assembly_token_scanner_unit.sv
tb/sv/testbench.sv
